@@ rtl/core/bucb_pkg.sv @@
// Shared types and constants of the bucketed UCB1 arm selector.
package bucb_pkg;

    // Table geometry.
    localparam int NUM_BUCKETS = 64;
    localparam int ARMS_PER_BUCKET = 4;
    localparam int BKT_W       = $clog2(NUM_BUCKETS);
    localparam int ARM_W       = $clog2(ARMS_PER_BUCKET);
    localparam int ENT_W       = BKT_W + ARM_W;
    localparam int NUM_ENTRIES = NUM_BUCKETS * ARMS_PER_BUCKET;

    // Field widths of the stored statistics.
    localparam int CNT_W  = 20;
    localparam int MEAN_W = 16;
    localparam int TOT_W  = 22;
    localparam int ARM_MEM_W = CNT_W + MEAN_W;

    // Arithmetic widths.
    localparam int LOGE_W = 5;
    localparam int FRAC_W = 16;
    localparam int LOG_W  = LOGE_W + FRAC_W;
    localparam int LN_W   = 21;
    localparam int MANT_W = 31;
    localparam int DVD_W  = 40;
    localparam int DVS_W  = 22;
    localparam int NUM_W  = 38;
    localparam int SCORE_W = 21;
    localparam int SQRT_W = 18;
    localparam int IT_W   = 6;

    // Iteration counts of the shared units.
    localparam int LOG_ITERS  = FRAC_W;
    localparam int DIV_ITERS  = DVD_W;
    localparam int SQRT_ITERS = DVD_W / 2;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [TOT_W-1:0] TOTAL_MAX = {TOT_W{1'b1}};
    localparam logic signed [MEAN_W-1:0] REWARD_HIT  = 16'sd16384;
    localparam logic signed [MEAN_W-1:0] REWARD_MISS = -16'sd8192;
    localparam logic signed [MEAN_W-1:0] MEAN_MAX    = 16'sd32767;
    localparam logic signed [MEAN_W-1:0] MEAN_MIN    = -16'sd32768;
    localparam logic [15:0] LN2_Q16 = 16'd45426;

    // Item kinds.
    localparam logic KIND_SELECT = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_CHK,
        ST_LOG0,
        ST_LOG_IT,
        ST_LN,
        ST_DIV_LD,
        ST_DIV,
        ST_SQ_LD,
        ST_SQ,
        ST_CMP,
        ST_OUT,
        ST_UPD_RD,
        ST_UPD_MUL,
        ST_UPD_PREP,
        ST_UPD_WR
    } t_state;

endpackage

@@ rtl/core/bucketed_ucb_arm_selector_top.sv @@
// Top level of the bucketed UCB1 arm selector: sequencer, shared units and statistics memories.
//
// The low six address bits pick one of 64 buckets, each a UCB1 bandit over four arms whose
// counts and means sit in one 256-entry memory and whose pull totals sit in a 64-entry memory,
// both with a registered read. Transactions are handled one at a time. A select reads the arms
// in order and answers at once with the first untried arm; when all four are tried it takes a
// 16-step log2 (skipped for a total of zero or one), then per arm a restoring divide and a
// 20-step square root. An update runs through the same divider. An ignored update (no select
// yet) leaves the block idle. The result sits in an output register, so a new transaction is
// taken while it waits. After reset a clearing pass over all 256 entries zeroes both memories,
// and the input stays closed until it is done.
module bucketed_ucb_arm_selector_top
    import bucb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_kind,
    input  logic [63:0] i_branch_address,
    input  logic        i_outcome_taken,
    input  logic        i_arm_prediction,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_chosen_arm
);

    // Statistics memories, their read registers and the clearing pass.
    logic [ARM_MEM_W-1:0] arm_mem [NUM_ENTRIES];
    logic [TOT_W-1:0]     tot_mem [NUM_BUCKETS];
    logic [ARM_MEM_W-1:0] r_arm_rd;
    logic [TOT_W-1:0]     r_tot_rd;
    logic                 r_clr_busy;
    logic [ENT_W-1:0]     r_clr_addr;

    t_state r_state, n_state;

    logic [BKT_W-1:0]  r_bucket, n_bucket;
    logic              r_hit, n_hit;
    logic              r_is_upd, n_is_upd;
    logic [ARM_W-1:0]  r_arm, n_arm;
    logic [CNT_W-1:0]  r_cnt [ARMS_PER_BUCKET];
    logic [CNT_W-1:0]  n_cnt [ARMS_PER_BUCKET];
    logic signed [MEAN_W-1:0] r_mean [ARMS_PER_BUCKET];
    logic signed [MEAN_W-1:0] n_mean [ARMS_PER_BUCKET];
    logic [TOT_W-1:0]  r_total, n_total;
    logic [ARM_W-1:0]  r_last_arm, n_last_arm;
    logic              r_last_vld, n_last_vld;
    logic [LOGE_W-1:0] r_log_e, n_log_e;
    logic [MANT_W-1:0] r_log_m, n_log_m;
    logic [FRAC_W-1:0] r_log_frac, n_log_frac;
    logic [IT_W-1:0]   r_it, n_it;
    logic [LN_W-1:0]   r_ln, n_ln;
    logic [DVD_W-1:0]  r_dvd_q, n_dvd_q;
    logic [DVS_W-1:0]  r_rem, n_rem;
    logic [DVS_W-1:0]  r_dvs, n_dvs;
    logic [DVD_W-1:0]  r_sq_v, n_sq_v;
    logic [DVD_W-1:0]  r_sq_r, n_sq_r;
    logic [DVD_W-1:0]  r_sq_bit, n_sq_bit;
    logic [ARM_W-1:0]  r_best_arm, n_best_arm;
    logic signed [SCORE_W-1:0] r_best_score, n_best_score;
    logic [CNT_W-1:0]  r_upd_n, n_upd_n;
    logic [TOT_W-1:0]  r_upd_tot, n_upd_tot;
    logic signed [NUM_W-1:0] r_num, n_num;
    logic              r_neg, n_neg;
    logic              r_out_valid, n_out_valid;
    logic [ARM_W-1:0]  r_out_arm, n_out_arm;

    // Combinational helpers.
    logic              in_acc;
    logic              last_arm_now;
    logic              out_free;
    logic [ENT_W-1:0]  arm_rd_addr;
    logic [ENT_W-1:0]  arm_wr_addr;
    logic              mem_we;
    logic [CNT_W-1:0]  cnt_eff;
    logic signed [MEAN_W-1:0] mean_eff;
    logic [TOT_W-1:0]  tot_eff;
    logic [LOGE_W-1:0] log_e;
    logic [TOT_W-1:0]  log_norm;
    logic [2*MANT_W-1:0] log_sq;
    logic [MANT_W:0]   log_t;
    logic [LOG_W+15:0] ln_prod;
    logic [DVS_W:0]    div_rem2;
    logic              div_ge;
    logic [DVD_W-1:0]  sq_try;
    logic signed [SCORE_W-1:0] score;
    logic [CNT_W-1:0]  upd_n;
    logic [CNT_W-1:0]  upd_nm1;
    logic signed [CNT_W+MEAN_W:0] upd_prod;
    logic signed [MEAN_W-1:0] upd_reward;
    logic [DVD_W-1:0]  upd_big_n;
    logic [CNT_W:0]    upd_d;
    logic signed [DVD_W:0] upd_q;
    logic signed [MEAN_W-1:0] upd_mean;

    assign in_acc       = i_in_valid && o_in_ready;
    assign last_arm_now = (r_arm == ARM_W'(ARMS_PER_BUCKET - 1));
    assign out_free     = !r_out_valid || i_out_ready;
    assign o_in_ready   = (r_state == ST_IDLE) && !r_clr_busy;
    assign o_out_valid  = r_out_valid;
    assign o_chosen_arm = r_out_arm;

    assign arm_rd_addr = {r_bucket, (r_state == ST_UPD_RD) ? r_last_arm : r_arm};
    assign arm_wr_addr = {r_bucket, r_last_arm};
    assign mem_we      = (r_state == ST_UPD_WR);

    // Fields of the words just read.
    assign cnt_eff  = r_arm_rd[ARM_MEM_W-1:MEAN_W];
    assign mean_eff = $signed(r_arm_rd[MEAN_W-1:0]);
    assign tot_eff  = r_tot_rd;

    // Position of the top set bit of the total and the normalized mantissa.
    always_comb begin
        log_e = '0;
        for (int b = 0; b < TOT_W; b++) begin
            if (r_total[b]) begin
                log_e = LOGE_W'(b);
            end
        end
        log_norm = r_total << (LOGE_W'(TOT_W - 1) - log_e);
    end

    // One squaring step of the log2 fraction.
    assign log_sq  = r_log_m * r_log_m;
    assign log_t   = log_sq[2*MANT_W-1:MANT_W-1];
    assign ln_prod = {r_log_e, r_log_frac} * LN2_Q16;

    // One restoring divide step.
    assign div_rem2 = {r_rem, r_dvd_q[DVD_W-1]};
    assign div_ge   = (div_rem2 >= {1'b0, r_dvs});

    // One square root step and the arm score.
    assign sq_try = r_sq_r + r_sq_bit;
    assign score  = SCORE_W'(r_mean[r_arm]) + $signed({3'b0, r_sq_r[SQRT_W-1:0]});

    // Update arithmetic: saturating count, numerator and signed floor division operands.
    assign upd_n      = (cnt_eff == COUNT_MAX) ? cnt_eff : cnt_eff + 1'b1;
    assign upd_nm1    = upd_n - 1'b1;
    assign upd_prod   = $signed({1'b0, upd_nm1}) * mean_eff;
    assign upd_reward = r_hit ? REWARD_HIT : REWARD_MISS;
    assign upd_big_n  = {r_num[NUM_W-1], r_num, 1'b0} + {{(DVD_W-CNT_W){1'b0}}, r_upd_n};
    assign upd_d      = {r_upd_n, 1'b0};
    assign upd_q      = r_neg ? -$signed({1'b0, r_dvd_q}) : $signed({1'b0, r_dvd_q});

    // Clamp of the new mean to the signed 16-bit range.
    always_comb begin
        if (upd_q > $signed((DVD_W+1)'(MEAN_MAX))) begin
            upd_mean = MEAN_MAX;
        end else if (upd_q < $signed((DVD_W+1)'(MEAN_MIN))) begin
            upd_mean = MEAN_MIN;
        end else begin
            upd_mean = upd_q[MEAN_W-1:0];
        end
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_kind == KIND_SELECT) begin
                        n_state = ST_SCAN;
                    end else if (r_last_vld) begin
                        n_state = ST_UPD_RD;
                    end
                end
            end
            ST_SCAN:     n_state = ST_SCAN_CHK;
            ST_SCAN_CHK: begin
                if (cnt_eff == '0) begin
                    n_state = ST_OUT;
                end else if (last_arm_now) begin
                    n_state = ST_LOG0;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_LOG0:   n_state = (r_total > TOT_W'(1)) ? ST_LOG_IT : ST_DIV_LD;
            ST_LOG_IT: n_state = (r_it == IT_W'(LOG_ITERS - 1)) ? ST_LN : ST_LOG_IT;
            ST_LN:     n_state = ST_DIV_LD;
            ST_DIV_LD: n_state = ST_DIV;
            ST_DIV: begin
                if (r_it == IT_W'(DIV_ITERS - 1)) begin
                    n_state = r_is_upd ? ST_UPD_WR : ST_SQ_LD;
                end
            end
            ST_SQ_LD: n_state = ST_SQ;
            ST_SQ:    n_state = (r_it == IT_W'(SQRT_ITERS - 1)) ? ST_CMP : ST_SQ;
            ST_CMP:   n_state = last_arm_now ? ST_OUT : ST_DIV_LD;
            ST_OUT:   n_state = out_free ? ST_IDLE : ST_OUT;
            ST_UPD_RD:   n_state = ST_UPD_MUL;
            ST_UPD_MUL:  n_state = ST_UPD_PREP;
            ST_UPD_PREP: n_state = ST_DIV;
            ST_UPD_WR:   n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // Datapath and output register updates.
    always_comb begin
        n_bucket     = r_bucket;
        n_hit        = r_hit;
        n_is_upd     = r_is_upd;
        n_arm        = r_arm;
        n_cnt        = r_cnt;
        n_mean       = r_mean;
        n_total      = r_total;
        n_last_arm   = r_last_arm;
        n_last_vld   = r_last_vld;
        n_log_e      = r_log_e;
        n_log_m      = r_log_m;
        n_log_frac   = r_log_frac;
        n_it         = r_it;
        n_ln         = r_ln;
        n_dvd_q      = r_dvd_q;
        n_rem        = r_rem;
        n_dvs        = r_dvs;
        n_sq_v       = r_sq_v;
        n_sq_r       = r_sq_r;
        n_sq_bit     = r_sq_bit;
        n_best_arm   = r_best_arm;
        n_best_score = r_best_score;
        n_upd_n      = r_upd_n;
        n_upd_tot    = r_upd_tot;
        n_num        = r_num;
        n_neg        = r_neg;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_arm    = r_out_arm;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_bucket = i_branch_address[BKT_W-1:0];
                    n_hit    = (i_outcome_taken == i_arm_prediction);
                    n_is_upd = (i_kind == KIND_UPDATE);
                    n_arm    = '0;
                end
            end
            ST_SCAN_CHK: begin
                n_cnt[r_arm]  = cnt_eff;
                n_mean[r_arm] = mean_eff;
                n_total       = tot_eff;
                if (cnt_eff == '0) begin
                    n_best_arm = r_arm;
                end else if (!last_arm_now) begin
                    n_arm = r_arm + 1'b1;
                end
            end
            ST_LOG0: begin
                n_ln       = '0;
                n_arm      = '0;
                n_log_e    = log_e;
                n_log_m    = {log_norm, {(MANT_W-TOT_W){1'b0}}};
                n_log_frac = '0;
                n_it       = '0;
            end
            ST_LOG_IT: begin
                n_log_frac = {r_log_frac[FRAC_W-2:0], log_t[MANT_W]};
                n_log_m    = log_t[MANT_W] ? log_t[MANT_W:1] : log_t[MANT_W-1:0];
                n_it       = r_it + 1'b1;
            end
            ST_LN: begin
                n_ln  = ln_prod[LN_W+15:16];
                n_arm = '0;
            end
            ST_DIV_LD: begin
                n_dvd_q = {{(DVD_W-LN_W-13){1'b0}}, r_ln, 13'b0};
                n_dvs   = {{(DVS_W-CNT_W){1'b0}}, r_cnt[r_arm]};
                n_rem   = '0;
                n_it    = '0;
            end
            ST_DIV: begin
                n_rem   = div_ge ? DVS_W'(div_rem2 - {1'b0, r_dvs}) : div_rem2[DVS_W-1:0];
                n_dvd_q = {r_dvd_q[DVD_W-2:0], div_ge};
                n_it    = r_it + 1'b1;
            end
            ST_SQ_LD: begin
                n_sq_v   = r_dvd_q;
                n_sq_r   = '0;
                n_sq_bit = {2'b01, {(DVD_W-2){1'b0}}};
                n_it     = '0;
            end
            ST_SQ: begin
                if (r_sq_v >= sq_try) begin
                    n_sq_v = r_sq_v - sq_try;
                    n_sq_r = (r_sq_r >> 1) + r_sq_bit;
                end else begin
                    n_sq_r = r_sq_r >> 1;
                end
                n_sq_bit = r_sq_bit >> 2;
                n_it     = r_it + 1'b1;
            end
            ST_CMP: begin
                if (r_arm == '0 || score > r_best_score) begin
                    n_best_score = score;
                    n_best_arm   = r_arm;
                end
                if (!last_arm_now) begin
                    n_arm = r_arm + 1'b1;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_arm   = r_best_arm;
                    n_last_arm  = r_best_arm;
                    n_last_vld  = 1'b1;
                end
            end
            ST_UPD_MUL: begin
                n_upd_n   = upd_n;
                n_upd_tot = (tot_eff == TOTAL_MAX) ? tot_eff : tot_eff + 1'b1;
                n_num     = NUM_W'(upd_prod) + NUM_W'(upd_reward);
            end
            ST_UPD_PREP: begin
                n_neg   = upd_big_n[DVD_W-1];
                n_dvd_q = upd_big_n[DVD_W-1]
                        ? (-upd_big_n + {{(DVD_W-CNT_W-1){1'b0}}, upd_d} - 1'b1)
                        : upd_big_n;
                n_dvs   = {{(DVS_W-CNT_W-1){1'b0}}, upd_d};
                n_rem   = '0;
                n_it    = '0;
            end
            default: begin
            end
        endcase
    end

    // Control registers and the clearing pass counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_last_arm  <= '0;
            r_last_vld  <= 1'b0;
            r_out_valid <= 1'b0;
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
        end else begin
            r_state     <= n_state;
            r_last_arm  <= n_last_arm;
            r_last_vld  <= n_last_vld;
            r_out_valid <= n_out_valid;
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == ENT_W'(NUM_ENTRIES - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_bucket     <= n_bucket;
        r_hit        <= n_hit;
        r_is_upd     <= n_is_upd;
        r_arm        <= n_arm;
        r_cnt        <= n_cnt;
        r_mean       <= n_mean;
        r_total      <= n_total;
        r_log_e      <= n_log_e;
        r_log_m      <= n_log_m;
        r_log_frac   <= n_log_frac;
        r_it         <= n_it;
        r_ln         <= n_ln;
        r_dvd_q      <= n_dvd_q;
        r_rem        <= n_rem;
        r_dvs        <= n_dvs;
        r_sq_v       <= n_sq_v;
        r_sq_r       <= n_sq_r;
        r_sq_bit     <= n_sq_bit;
        r_best_arm   <= n_best_arm;
        r_best_score <= n_best_score;
        r_upd_n      <= n_upd_n;
        r_upd_tot    <= n_upd_tot;
        r_num        <= n_num;
        r_neg        <= n_neg;
        r_out_arm    <= n_out_arm;
    end

    // Memory ports: one registered read and one write per memory; the clearing pass writes zeros.
    always_ff @(posedge i_clk) begin
        r_arm_rd <= arm_mem[arm_rd_addr];
        r_tot_rd <= tot_mem[r_bucket];
        if (r_clr_busy) begin
            arm_mem[r_clr_addr]            <= '0;
            tot_mem[r_clr_addr[BKT_W-1:0]] <= '0;
        end else if (mem_we) begin
            arm_mem[arm_wr_addr] <= {r_upd_n, upd_mean};
            tot_mem[r_bucket]    <= r_upd_tot;
        end
    end

endmodule

@@ rtl/core/bucb_checker.sv @@
// Port-level assertions of the arm selector and their bind to the top level.
module bucb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_kind,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_chosen_arm
);

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn before it was taken");

    // A stalled result keeps its arm.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_chosen_arm))
        else $error("result changed while stalled");

    // Reset leaves no result pending.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result pending after reset");

    // No transaction produces its result in the very next cycle.
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_out_valid |=> !i_out_valid)
        else $error("result appeared one cycle after a transaction");

    // A select occupies the block, so the input closes after it.
    a_sel_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_kind |=> !i_in_ready)
        else $error("input stayed open after a select");

endmodule

bind bucketed_ucb_arm_selector_top bucb_checker u_bucb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .i_in_ready   (o_in_ready),
    .i_kind       (i_kind),
    .i_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .i_chosen_arm (o_chosen_arm)
);
